// File: src/idmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idmr_pkg
// shared types, register map and constants of the int8 dense mac/requantize
// ----------------------------------------------------------------------------
package idmr_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IN_TDATA_W = 48;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_IN_ZP    = 3'd0;
  localparam reg_idx_t REG_OUT_ZP   = 3'd1;
  localparam reg_idx_t REG_MULT     = 3'd2;
  localparam reg_idx_t REG_SHIFT    = 3'd3;
  localparam reg_idx_t REG_CLAMP_LO = 3'd4;
  localparam reg_idx_t REG_CLAMP_HI = 3'd5;

  localparam logic [7:0]  RST_IN_ZP    = 8'h00;
  localparam logic [7:0]  RST_OUT_ZP   = 8'h00;
  localparam logic [31:0] RST_MULT     = 32'h4000_0000;
  localparam logic [5:0]  RST_SHIFT    = 6'h00;
  localparam logic [7:0]  RST_CLAMP_LO = 8'h80;
  localparam logic [7:0]  RST_CLAMP_HI = 8'h7F;

  localparam logic [63:0] NUDGE_POS  = 64'h0000_0000_4000_0000;
  localparam logic [63:0] NUDGE_NEG  = 64'hFFFF_FFFF_C000_0001;
  localparam logic [63:0] Q31_BIAS   = 64'h0000_0000_7FFF_FFFF;
  localparam logic [31:0] Q31_MIN    = 32'h8000_0000;
  localparam logic [31:0] Q31_MAX    = 32'h7FFF_FFFF;
  localparam logic [4:0]  SHIFT_MAX  = 5'd31;

  typedef struct packed {
    logic [7:0]  in_zp;
    logic [7:0]  out_zp;
    logic [31:0] mult;
    logic [5:0]  shift;
    logic [7:0]  clamp_lo;
    logic [7:0]  clamp_hi;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_MAC,
    ST_SHIFT,
    ST_MUL,
    ST_NUDGE,
    ST_SCALE,
    ST_ROUND,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic mac_en;
    logic shift_en;
    logic mul_en;
    logic nudge_en;
    logic scale_en;
    logic round_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage : idmr_pkg
`default_nettype wire

// File: src/int8_dense_mac_requantize.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int8_dense_mac_requantize
// one int8 dense-layer neuron: mac over a run of beats, then requantize
// ----------------------------------------------------------------------------
// channel  dir  signals                      content
// in       in   in_tdata/in_tuser/in_tlast   activation, weight, bias / first / last
// out      out  out_tdata                    out_value
// cfg      in   cfg_p*                       zero points, multiplier, shift, clamps
//
// a beat without last is taken every cycle, one mac per cycle
// a last beat holds in_tready low while the requantize
// stages (shift, 32x32 multiply, nudge, scale, round, clamp) run in turn
// the result sits in an output register; the input stalls longer only if a new
// result is ready before the previous one is taken
// reset is synchronous, active low; the accumulator clears to zero
// ----------------------------------------------------------------------------
module int8_dense_mac_requantize (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // activation [7:0], weight [15:8], bias [47:16]
  input  wire logic [idmr_pkg::IN_TDATA_W-1:0]    in_tdata,
  // first
  input  wire logic                               in_tuser,
  input  wire logic                               in_tlast,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // out_value [7:0]
  output logic      [idmr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [idmr_pkg::ADDR_W-1:0]        cfg_paddr,
  input  wire logic [idmr_pkg::DATA_W-1:0]        cfg_pwdata,
  output logic      [idmr_pkg::DATA_W-1:0]        cfg_prdata,
  output logic                                    cfg_pready
);
  import idmr_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  idmr_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  idmr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  idmr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule : int8_dense_mac_requantize
`default_nettype wire

// File: src/idmr_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idmr_cfg_regs
// apb register file holding zero points, multiplier, shift and clamp bounds
// ----------------------------------------------------------------------------
module idmr_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [idmr_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [idmr_pkg::DATA_W-1:0] cfg_pwdata,
  output logic      [idmr_pkg::DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready,
  output idmr_pkg::cfg_t                  cfg
);
  import idmr_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = cfg_paddr[ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_IN_ZP:    cfg_nxt.in_zp    = cfg_pwdata[7:0];
        REG_OUT_ZP:   cfg_nxt.out_zp   = cfg_pwdata[7:0];
        REG_MULT:     cfg_nxt.mult     = cfg_pwdata[31:0];
        REG_SHIFT:    cfg_nxt.shift    = cfg_pwdata[5:0];
        REG_CLAMP_LO: cfg_nxt.clamp_lo = cfg_pwdata[7:0];
        REG_CLAMP_HI: cfg_nxt.clamp_hi = cfg_pwdata[7:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IN_ZP:    cfg_prdata = {24'd0, cfg_r.in_zp};
      REG_OUT_ZP:   cfg_prdata = {24'd0, cfg_r.out_zp};
      REG_MULT:     cfg_prdata = cfg_r.mult;
      REG_SHIFT:    cfg_prdata = {26'd0, cfg_r.shift};
      REG_CLAMP_LO: cfg_prdata = {24'd0, cfg_r.clamp_lo};
      REG_CLAMP_HI: cfg_prdata = {24'd0, cfg_r.clamp_hi};
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_zp    <= RST_IN_ZP;
      cfg_r.out_zp   <= RST_OUT_ZP;
      cfg_r.mult     <= RST_MULT;
      cfg_r.shift    <= RST_SHIFT;
      cfg_r.clamp_lo <= RST_CLAMP_LO;
      cfg_r.clamp_hi <= RST_CLAMP_HI;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule : idmr_cfg_regs
`default_nettype wire

// File: src/idmr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idmr_ctrl
// sequencer: accepts mac beats, then steps the requantize stages one per cycle
// ----------------------------------------------------------------------------
module idmr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_tlast,
  output logic               in_tready,
  input  idmr_pkg::sts_t     sts,
  output idmr_pkg::cmd_t     cmd
);
  import idmr_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   in_fire;

  assign in_fire = in_tvalid & in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_MAC:    if (in_fire && in_tlast) state_nxt = ST_SHIFT;
      ST_SHIFT:  state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_NUDGE;
      ST_NUDGE:  state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = ST_FINISH;
      ST_FINISH: if (!sts.out_full) state_nxt = ST_MAC;
      default:   state_nxt = ST_MAC;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_MAC: begin
        in_tready  = 1'b1;
        cmd.mac_en = in_tvalid;
      end
      ST_SHIFT:  cmd.shift_en = 1'b1;
      ST_MUL:    cmd.mul_en   = 1'b1;
      ST_NUDGE:  cmd.nudge_en = 1'b1;
      ST_SCALE:  cmd.scale_en = 1'b1;
      ST_ROUND:  cmd.round_en = 1'b1;
      ST_FINISH: cmd.out_load = !sts.out_full;
      default: begin
        cmd       = '0;
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_MAC;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_full)
    else $error("result loaded over a pending beat");

  a_last_starts_requant: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (state_r == ST_SHIFT))
    else $error("last beat did not start requantization");

  a_no_accept_in_requant: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> !in_tready ##1 !in_tready)
    else $error("input accepted during requantization");

  a_finish_exits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (state_r == ST_MAC))
    else $error("sequencer stuck after result load");

endmodule : idmr_ctrl
`default_nettype wire

// File: src/idmr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idmr_dp
// accumulator, requantize stages and result register
// ----------------------------------------------------------------------------
module idmr_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  idmr_pkg::cfg_t                       cfg,
  input  idmr_pkg::cmd_t                       cmd,
  output idmr_pkg::sts_t                       sts,
  input  wire logic [idmr_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [idmr_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import idmr_pkg::*;

  logic signed [7:0]  act;
  logic signed [7:0]  wgt;
  logic        [31:0] bias;
  logic signed [8:0]  diff;
  logic signed [16:0] prod;
  logic        [31:0] acc_base;
  logic        [31:0] acc_r;
  logic        [31:0] acc_nxt;

  logic signed [5:0]  sh;
  logic        [5:0]  neg_sh;
  logic        [4:0]  left;
  logic        [4:0]  right;
  logic        [31:0] v_r;
  logic        [4:0]  right_r;
  logic signed [63:0] ab_r;
  logic               sat_r;
  logic signed [63:0] t_r;
  logic               sat_t_r;
  logic signed [63:0] t_adj;
  logic signed [63:0] t_div;
  logic        [31:0] q_r;

  logic        [31:0] mask;
  logic        [31:0] rem;
  logic        [31:0] thr;
  logic signed [31:0] fl;
  logic signed [32:0] rnd_r;
  logic signed [33:0] r_ofs;
  logic signed [33:0] r_lo;
  logic signed [33:0] r_hi;
  logic signed [33:0] r_c;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic        [7:0]  out_data_r;

  // accumulate
  assign act      = in_tdata[7:0];
  assign wgt      = in_tdata[15:8];
  assign bias     = in_tdata[47:16];
  assign diff     = {act[7], act} - {cfg.in_zp[7], cfg.in_zp};
  assign prod     = diff * wgt;
  assign acc_base = in_tuser ? bias : acc_r;
  assign acc_nxt  = acc_base + {{15{prod[16]}}, prod};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.mac_en) begin
      acc_r <= acc_nxt;
    end
  end

  // shift split
  assign sh     = cfg.shift;
  assign neg_sh = 6'd0 - cfg.shift;
  assign left   = (!sh[5] && (sh != 6'sd0)) ? sh[4:0] : 5'd0;
  assign right  = !sh[5] ? 5'd0 : (neg_sh[5] ? SHIFT_MAX : neg_sh[4:0]);

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      v_r     <= acc_r << left;
      right_r <= right;
    end
    if (cmd.mul_en) begin
      ab_r  <= $signed(v_r) * $signed(cfg.mult);
      sat_r <= (v_r == Q31_MIN) && (cfg.mult == Q31_MIN);
    end
    if (cmd.nudge_en) begin
      t_r     <= ab_r + (ab_r[63] ? $signed(NUDGE_NEG) : $signed(NUDGE_POS));
      sat_t_r <= sat_r;
    end
  end

  // divide by 2^31 toward zero
  assign t_adj = t_r[63] ? (t_r + $signed(Q31_BIAS)) : t_r;
  assign t_div = t_adj >>> 31;

  always_ff @(posedge clk) begin
    if (cmd.scale_en) begin
      q_r <= sat_t_r ? Q31_MAX : t_div[31:0];
    end
  end

  // rounding right shift, ties away from zero
  assign mask = (32'd1 << right_r) - 32'd1;
  assign rem  = q_r & mask;
  assign thr  = (mask >> 1) + {31'd0, q_r[31]};
  assign fl   = $signed(q_r) >>> right_r;

  always_ff @(posedge clk) begin
    if (cmd.round_en) begin
      rnd_r <= {fl[31], fl} + {32'd0, (rem > thr)};
    end
  end

  // offset and clamp
  assign r_ofs = {rnd_r[32], rnd_r} + {{26{cfg.out_zp[7]}}, cfg.out_zp};
  assign r_lo  = {{26{cfg.clamp_lo[7]}}, cfg.clamp_lo};
  assign r_hi  = {{26{cfg.clamp_hi[7]}}, cfg.clamp_hi};

  always_comb begin
    r_c = r_ofs;
    if (r_c < r_lo) r_c = r_lo;
    if (r_c > r_hi) r_c = r_hi;
  end

  // result register
  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= r_c[7:0];
    end
  end

  assign sts.out_full = out_valid_r & ~out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

endmodule : idmr_dp
`default_nettype wire
